>>> design/hsl_pkg.sv
`default_nettype none
package hsl_pkg;
   typedef enum logic [0:0] {
      REG_SAT = 1'b0,
      REG_HUE = 1'b1
   } reg_idx_type;
   localparam int unsigned PIX_W = 8;
endpackage
`default_nettype wire

>>> design/hsl_hue_saturation_adjust.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_red_in, req_green_in, req_blue_in
// rsp       out        rsp_valid/rsp_stall   rsp_red_out, rsp_green_out, rsp_blue_out
// csr       in/out     APB-style, pready=1   saturation_adjust @0x0, hue_adjust @0x4
// One transaction enters per cycle while rsp_stall is low; on its way to rsp it
// passes FRAC_BITS+1 divider stages (both restoring dividers side by side,
// one quotient bit per stage) and eight more stages.
// Synchronous active-high reset clears valid bits and both adjust registers.
// A stall on rsp freezes the whole pipeline; req_stall follows rsp_stall.
`default_nettype none
module hsl_hue_saturation_adjust #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [hsl_pkg::PIX_W-1:0]   req_red_in,
   input  wire logic [hsl_pkg::PIX_W-1:0]   req_green_in,
   input  wire logic [hsl_pkg::PIX_W-1:0]   req_blue_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [hsl_pkg::PIX_W-1:0]        rsp_red_out,
   output logic [hsl_pkg::PIX_W-1:0]        rsp_green_out,
   output logic [hsl_pkg::PIX_W-1:0]        rsp_blue_out,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [2:0]                  csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   localparam int unsigned F  = FRAC_BITS;
   localparam int unsigned W  = F + 2;          // unit values 0..ONE
   localparam int unsigned SW = F + 12;         // signed working width
   localparam int unsigned ND = F;              // fractional divider stages
   localparam logic [W-1:0] ONE   = W'(1) << F;
   localparam logic [W-1:0] SIXTH = W'((64'd1 << F) / 6);
   localparam logic [W-1:0] HALF  = W'((64'd1 << F) / 2);
   localparam logic [W-1:0] TWO3  = W'((64'd2 << F) / 3);
   localparam logic [W-1:0] THIRD = W'((64'd1 << F) / 3);

   // ---------------- configuration ----------------
   logic signed [7:0] sat_adj_ff, hue_adj_ff;
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         sat_adj_ff <= '0;
         hue_adj_ff <= '0;
      end else if (csr_wr && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == hsl_pkg::REG_SAT) sat_adj_ff <= csr_pwdata[7:0];
         else hue_adj_ff <= csr_pwdata[7:0];
      end
   end
   always_comb begin
      case (csr_paddr)
         {hsl_pkg::REG_SAT, 2'b00}: csr_prdata = {{24{sat_adj_ff[7]}}, sat_adj_ff};
         {hsl_pkg::REG_HUE, 2'b00}: csr_prdata = {{24{hue_adj_ff[7]}}, hue_adj_ff};
         default: csr_prdata = '0;
      endcase
   end

   // offsets: adjust*ONE/100 truncated toward zero, via magnitude * reciprocal
   localparam int unsigned RK = F + 24;
   localparam logic [RK-7:0] RECIP = (RK-6)'(((64'd1 << RK) + 99) / 100);
   function automatic logic signed [W:0] pct_off(input logic signed [7:0] a);
      logic [7:0]      m;
      logic [RK+1:0]   pr;
      logic [W-1:0]    q;
      m  = a[7] ? 8'(-a) : 8'(a);
      pr = (RK+2)'(m) * (RK+2)'(RECIP);
      q  = W'(pr >> (RK - F));
      pct_off = a[7] ? -(W+1)'(q) : (W+1)'(q);
   endfunction
   logic signed [W:0] sat_off_ff, hue_off_ff;
   always_ff @(posedge clock) begin
      sat_off_ff <= pct_off(sat_adj_ff);
      hue_off_ff <= pct_off(hue_adj_ff);
   end

   // ---------------- pipeline control ----------------
   logic adv;
   assign adv       = !rsp_stall;
   assign req_stall = rsp_stall;

   // ---------------- stage A: max/min ----------------
   logic a_v_ff;
   logic [7:0] a_r_ff, a_g_ff, a_b_ff, a_mx_ff, a_mn_ff;
   logic [1:0] a_sel_ff;   // 0 red, 1 green, 2 blue
   logic [7:0] mx_in, mn_in;
   logic [1:0] sel_in;
   always_comb begin
      mx_in = req_red_in; sel_in = 2'd0;
      if (req_green_in > mx_in) begin mx_in = req_green_in; sel_in = 2'd1; end
      if (req_blue_in > mx_in) begin mx_in = req_blue_in; sel_in = 2'd2; end
      mn_in = req_red_in;
      if (req_green_in < mn_in) mn_in = req_green_in;
      if (req_blue_in < mn_in) mn_in = req_blue_in;
   end
   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (adv) a_v_ff <= req_valid;
      if (adv) begin
         a_r_ff <= req_red_in; a_g_ff <= req_green_in; a_b_ff <= req_blue_in;
         a_mx_ff <= mx_in; a_mn_ff <= mn_in; a_sel_ff <= sel_in;
      end
   end

   // ---------------- stage B: operands for dividers ----------------
   logic b_v_ff, b_gray_ff, b_low_ff;
   logic [8:0]  b_sum_ff, b_sden_ff;
   logic [7:0]  b_delta_ff;
   logic [10:0] b_hnum_ff, b_hden_ff;
   logic [8:0]  sum_c;
   logic [7:0]  dl_c;
   logic signed [11:0] num_c;
   always_comb begin
      sum_c = 9'(a_mx_ff) + 9'(a_mn_ff);
      dl_c  = a_mx_ff - a_mn_ff;
      case (a_sel_ff)
         2'd0: num_c = 12'(signed'({1'b0, a_g_ff})) - 12'(signed'({1'b0, a_b_ff}))
                     + ((a_g_ff < a_b_ff) ? 12'(6 * dl_c) : 12'sd0);
         2'd1: num_c = 12'(signed'({1'b0, a_b_ff})) - 12'(signed'({1'b0, a_r_ff}))
                     + 12'(2 * dl_c);
         default: num_c = 12'(signed'({1'b0, a_r_ff})) - 12'(signed'({1'b0, a_g_ff}))
                     + 12'(4 * dl_c);
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (adv) b_v_ff <= a_v_ff;
      if (adv) begin
         b_sum_ff   <= sum_c;
         b_delta_ff <= dl_c;
         b_gray_ff  <= (dl_c == 8'd0);
         b_low_ff   <= (sum_c < 9'd255);
         b_sden_ff  <= (dl_c == 8'd0) ? 9'd1 :
                       ((sum_c < 9'd255) ? sum_c : 9'(10'd510 - 10'(sum_c)));
         b_hnum_ff  <= num_c[11] ? 11'd0 : num_c[10:0];
         b_hden_ff  <= (dl_c == 8'd0) ? 11'd1 : 11'(6 * dl_c);
      end
   end

   // ---------------- stages D: restoring dividers, one bit per stage ----------
   // sat: delta*ONE/den (quotient <= ONE); hue: num*ONE/hden (< ONE)
   // Lightness computed by reciprocal multiply alongside.
   localparam int unsigned LK = F + 20;
   localparam logic [LK-8:0] LREC = (LK-7)'(((64'd1 << LK) + 509) / 510);
   logic [W-1:0] d_lig_ff [ND+1];
   logic        d_v_ff    [ND+1];
   logic        d_gray_ff [ND+1];
   logic        d_low_ff  [ND+1];
   logic [10:0] d_srem_ff [ND+1];
   logic [8:0]  d_sden_ff [ND+1];
   logic [W-1:0] d_sq_ff  [ND+1];
   logic [11:0] d_hrem_ff [ND+1];
   logic [10:0] d_hden_ff [ND+1];
   logic [W-1:0] d_hq_ff  [ND+1];
   logic [LK:0] lig_prod;
   assign lig_prod = (LK+1)'(b_sum_ff) * (LK+1)'(LREC);

   always_ff @(posedge clock) begin
      if (reset) d_v_ff[0] <= 1'b0;
      else if (adv) d_v_ff[0] <= b_v_ff;
      if (adv) begin
         d_lig_ff[0]  <= W'(lig_prod >> (LK - F));
         d_gray_ff[0] <= b_gray_ff;
         d_low_ff[0]  <= b_low_ff;
         // integer part first: delta/den and num/hden
         d_srem_ff[0] <= (11'(b_delta_ff) >= 11'(b_sden_ff)) ?
                         11'(b_delta_ff) - 11'(b_sden_ff) : 11'(b_delta_ff);
         d_sq_ff[0]   <= W'(11'(b_delta_ff) >= 11'(b_sden_ff));
         d_sden_ff[0] <= b_sden_ff;
         d_hrem_ff[0] <= (b_hnum_ff >= b_hden_ff) ?
                         12'(b_hnum_ff - b_hden_ff) : 12'(b_hnum_ff);
         d_hq_ff[0]   <= W'(b_hnum_ff >= b_hden_ff);
         d_hden_ff[0] <= b_hden_ff;
      end
   end
   for (genvar k = 0; k < ND; k++) begin : g_div
      logic [11:0] s2, h2;
      logic        sbit, hbit;
      assign s2   = {d_srem_ff[k], 1'b0};
      assign h2   = {d_hrem_ff[k][10:0], 1'b0};
      assign sbit = s2 >= 12'(d_sden_ff[k]);
      assign hbit = h2 >= 12'(d_hden_ff[k]);
      always_ff @(posedge clock) begin
         if (reset) d_v_ff[k+1] <= 1'b0;
         else if (adv) d_v_ff[k+1] <= d_v_ff[k];
         if (adv) begin
            d_lig_ff[k+1]  <= d_lig_ff[k];
            d_gray_ff[k+1] <= d_gray_ff[k];
            d_low_ff[k+1]  <= d_low_ff[k];
            d_sden_ff[k+1] <= d_sden_ff[k];
            d_hden_ff[k+1] <= d_hden_ff[k];
            d_srem_ff[k+1] <= sbit ? 11'(s2 - 12'(d_sden_ff[k])) : s2[10:0];
            d_hrem_ff[k+1] <= hbit ? (h2 - 12'(d_hden_ff[k])) : h2;
            d_sq_ff[k+1]   <= {d_sq_ff[k][W-2:0], sbit};
            d_hq_ff[k+1]   <= {d_hq_ff[k][W-2:0], hbit};
         end
      end
   end

   // ---------------- stage E: offsets and clamp ----------------
   logic e_v_ff, e_low_ff;
   logic [W-1:0] e_lig_ff, e_sat_ff, e_hue_ff;
   function automatic logic [W-1:0] clamp_u(input logic signed [W+1:0] x);
      if (x < 0) clamp_u = '0;
      else if (x > signed'((W+2)'(ONE))) clamp_u = ONE;
      else clamp_u = W'(x);
   endfunction
   logic signed [W+1:0] s_sum, h_sum;
   assign s_sum = signed'((W+2)'(d_gray_ff[ND] ? W'(0) : d_sq_ff[ND]))
                + (W+2)'(sat_off_ff);
   assign h_sum = signed'((W+2)'(d_gray_ff[ND] ? W'(0) : d_hq_ff[ND]))
                + (W+2)'(hue_off_ff);
   always_ff @(posedge clock) begin
      if (reset) e_v_ff <= 1'b0;
      else if (adv) e_v_ff <= d_v_ff[ND];
      if (adv) begin
         e_low_ff <= d_low_ff[ND];
         e_lig_ff <= d_lig_ff[ND];
         e_sat_ff <= clamp_u(s_sum);
         e_hue_ff <= clamp_u(h_sum);
      end
   end

   // ---------------- stage M: L*S product ----------------
   logic m_v_ff, m_low_ff;
   logic [W-1:0] m_lig_ff, m_sat_ff, m_hue_ff;
   logic [2*W-1:0] m_ls_ff;
   always_ff @(posedge clock) begin
      if (reset) m_v_ff <= 1'b0;
      else if (adv) m_v_ff <= e_v_ff;
      if (adv) begin
         m_low_ff <= e_low_ff; m_lig_ff <= e_lig_ff;
         m_sat_ff <= e_sat_ff; m_hue_ff <= e_hue_ff;
         m_ls_ff  <= (2*W)'(e_lig_ff) * (2*W)'(e_sat_ff);
      end
   end

   // ---------------- stage Q: q, p, per-channel t and 6d ----------------
   logic q_v_ff;
   logic signed [SW-1:0] q_p_ff, q_q_ff;
   logic [W+2:0] q_d6_ff;
   logic signed [SW-1:0] q_t_ff [3];
   logic signed [SW-1:0] qv, pv, dv;
   logic [W-1:0] lsf;
   assign lsf = W'(m_ls_ff >> F);
   always_comb begin
      // low: L*(ONE+S)>>F = L + (L*S)>>F
      if (m_low_ff) qv = SW'(m_lig_ff) + SW'(lsf);
      else          qv = SW'(m_lig_ff) + SW'(m_sat_ff) - SW'(lsf);
      pv = (SW'(m_lig_ff) <<< 1) - qv;
      dv = qv - pv;
      if (dv < 0) dv = '0;
   end
   function automatic logic signed [SW-1:0] wrap_t(input logic signed [SW-1:0] t);
      logic signed [SW-1:0] u;
      u = t;
      if (u < 0) u = u + SW'(ONE);
      if (u > SW'(ONE)) u = u - SW'(ONE);
      if (u < 0) u = '0;
      wrap_t = u;
   endfunction
   always_ff @(posedge clock) begin
      if (reset) q_v_ff <= 1'b0;
      else if (adv) q_v_ff <= m_v_ff;
      if (adv) begin
         q_p_ff  <= pv;
         q_q_ff  <= qv;
         q_d6_ff <= (W+3)'(dv) * (W+3)'(6);
         q_t_ff[0] <= wrap_t(SW'(m_hue_ff) + SW'(THIRD));
         q_t_ff[1] <= wrap_t(SW'(m_hue_ff));
         q_t_ff[2] <= wrap_t(SW'(m_hue_ff) - SW'(THIRD));
      end
   end

   // ---------------- stage T: piece select and product ----------------
   logic t_v_ff;
   logic [1:0] t_kind_ff [3];   // 0 ramp, 1 q, 2 p
   logic [2*W+2:0] t_prod_ff [3];
   logic signed [SW-1:0] t_p_ff, t_q_ff;
   for (genvar c = 0; c < 3; c++) begin : g_tch
      logic [W-1:0] tt;
      logic [1:0]   kind;
      assign tt = W'(q_t_ff[c]);
      always_comb begin
         if (tt < SIXTH)     kind = 2'd0;
         else if (tt < HALF) kind = 2'd1;
         else if (tt < TWO3) kind = 2'd0;
         else                kind = 2'd2;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            t_kind_ff[c] <= kind;
            t_prod_ff[c] <= (2*W+3)'(q_d6_ff) *
                            (2*W+3)'((tt < SIXTH) ? tt : W'(TWO3 - tt));
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) t_v_ff <= 1'b0;
      else if (adv) t_v_ff <= q_v_ff;
      if (adv) begin
         t_p_ff <= q_p_ff;
         t_q_ff <= q_q_ff;
      end
   end

   // ---------------- stage V: channel value ----------------
   logic v_v_ff;
   logic signed [SW-1:0] v_val_ff [3];
   for (genvar c = 0; c < 3; c++) begin : g_vch
      always_ff @(posedge clock) begin
         if (adv) begin
            case (t_kind_ff[c])
               2'd0:    v_val_ff[c] <= t_p_ff + SW'(t_prod_ff[c] >> F);
               2'd1:    v_val_ff[c] <= t_q_ff;
               default: v_val_ff[c] <= t_p_ff;
            endcase
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v_v_ff <= 1'b0;
      else if (adv) v_v_ff <= t_v_ff;
   end

   // ---------------- stage O: scale by 255, clamp ----------------
   logic o_v_ff;
   logic [7:0] o_ch_ff [3];
   for (genvar c = 0; c < 3; c++) begin : g_och
      logic [SW+8:0] sc;
      logic [SW+8:0] cb;
      assign sc = (SW+9)'(v_val_ff[c]) * (SW+9)'(255);
      assign cb = sc >> F;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (v_val_ff[c] <= 0)        o_ch_ff[c] <= 8'd0;
            else if (cb > (SW+9)'(255))  o_ch_ff[c] <= 8'd255;
            else                         o_ch_ff[c] <= cb[7:0];
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else if (adv) o_v_ff <= v_v_ff;
   end

   assign rsp_valid     = o_v_ff;
   assign rsp_red_out   = o_ch_ff[0];
   assign rsp_green_out = o_ch_ff[1];
   assign rsp_blue_out  = o_ch_ff[2];

   // ---------------- assertions ----------------
   a_stall_holds_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_out))
      else $error("output changed under stall");
   a_stall_follows: assert property (@(posedge clock) disable iff (reset)
      req_stall == rsp_stall)
      else $error("input stall not tied to output stall");
   a_gray_sq: assert property (@(posedge clock) disable iff (reset)
      d_v_ff[ND] && d_gray_ff[ND] |-> d_sq_ff[ND] == W'(0))
      else $error("gray pixel saturation not zero");
endmodule
`default_nettype wire

>>> sim/hsl_adjust_checker.sv
`timescale 1ns / 100ps
module hsl_adjust_checker #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [7:0]  rsp_red_out,
   input  wire logic [7:0]  rsp_green_out,
   input  wire logic [7:0]  rsp_blue_out,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               fail_count,
   output int               pending_count,
   output int               pixel_count
);
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   localparam longint ONE = longint'(1) << FRAC_BITS;

   longint sat_offset_pct;
   longint hue_offset_pct;
   pixel_type expected_pixels[$];

   function automatic longint fx_mul(longint a, longint b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   function automatic longint unit_clamp(longint x);
      return (x < 0) ? 0 : ((x > ONE) ? ONE : x);
   endfunction

   function automatic longint hue_to_level(longint p, longint q, longint t);
      longint d;
      d = (q - p < 0) ? 0 : q - p;
      if (t < 0) t += ONE;
      if (t > ONE) t -= ONE;
      if (t < 0) t = 0;
      if (t < ONE / 6) return p + fx_mul(d * 6, t);
      if (t < ONE / 2) return q;
      if (t < (2 * ONE) / 3) return p + fx_mul(d * 6, (2 * ONE) / 3 - t);
      return p;
   endfunction

   function automatic logic [7:0] level_to_byte(longint v);
      longint c;
      if (v <= 0) return 8'd0;
      c = (v * 255) >>> FRAC_BITS;
      return (c > 255) ? 8'd255 : c[7:0];
   endfunction

   function automatic pixel_type adjust_pixel(pixel_type px);
      longint r, g, b, mx, mn, sum, delta, lig, sat, hue, num, den, q, p;
      pixel_type res;
      r = px.red;
      g = px.green;
      b = px.blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sum = mx + mn;
      delta = mx - mn;
      lig = (sum * ONE) / 510;
      sat = 0;
      hue = 0;
      if (delta > 0) begin
         den = (sum < 255) ? sum : 510 - sum;
         sat = (delta * ONE) / den;
         if (mx == r) num = (g - b) + ((g < b) ? 6 * delta : 0);
         else if (mx == g) num = (b - r) + 2 * delta;
         else num = (r - g) + 4 * delta;
         if (num < 0) num = 0;
         hue = (num * ONE) / (6 * delta);
      end
      sat = unit_clamp(sat + (sat_offset_pct * ONE) / 100);
      hue = unit_clamp(hue + (hue_offset_pct * ONE) / 100);
      if (sum < 255) q = fx_mul(lig, ONE + sat);
      else q = lig + sat - fx_mul(lig, sat);
      p = 2 * lig - q;
      res.red = level_to_byte(hue_to_level(p, q, hue + ONE / 3));
      res.green = level_to_byte(hue_to_level(p, q, hue));
      res.blue = level_to_byte(hue_to_level(p, q, hue - ONE / 3));
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (reset) begin
         sat_offset_pct <= 0;
         hue_offset_pct <= 0;
         expected_pixels.delete();
         fail_count <= 0;
         pending_count <= 0;
         pixel_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == hsl_pkg::REG_SAT)
               sat_offset_pct <= longint'($signed(csr_pwdata[7:0]));
            if (csr_paddr[2] == hsl_pkg::REG_HUE)
               hue_offset_pct <= longint'($signed(csr_pwdata[7:0]));
         end
         if (req_valid && !req_stall) begin
            expected_pixels.push_back(adjust_pixel({req_red_in, req_green_in, req_blue_in}));
            pixel_count <= pixel_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_red_out, rsp_green_out, rsp_blue_out};
            if (expected_pixels.size() == 0) begin
               if (fail_count < 10) $display("unexpected pixel %h at %0t", got, $realtime);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                              want.red, want.green, want.blue,
                              got.red, got.green, got.blue);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_pixels.size();
      end
   end
endmodule

>>> sim/hsl_hue_saturation_adjust_tb.sv
`timescale 1ns / 100ps
module hsl_hue_saturation_adjust_tb;
   localparam int unsigned FRAC_BITS = 16;
   localparam int LATENCY = 2 * FRAC_BITS + 24;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_red_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_blue_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_count;
   int          pixel_count;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_off_cycles = 0;
   int          hold_off_count = 0;
   int          hold_off_done = 0;
   logic [7:0]  sat_values [6] = '{8'd0, 8'd100, 8'h9C, 8'd127, 8'h80, 8'd37};
   logic [7:0]  hue_values [6] = '{8'd0, 8'h9C, 8'd100, 8'h80, 8'd127, 8'hE5};

   always #1 clock = ~clock;

   hsl_hue_saturation_adjust #(.FRAC_BITS(FRAC_BITS)) DUT (.*);

   hsl_adjust_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // stall the result side, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (hold_off_done != hold_off_count) begin
         hold_off_done <= hold_off_count;
         hold_off_cycles <= 3 * LATENCY;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic write_reg(input hsl_pkg::reg_idx_type idx, input logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {{24{value[7]}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || hold_off_cycles != 0 || hold_off_done != hold_off_count)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_random_pixels(input int count);
      logic [7:0] r, g, b;
      for (int i = 0; i < count; i++) begin
         r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
         case ($urandom_range(5))
            0: g = r;
            1: b = g;
            2: begin g = r; b = r; end
            default: ;
         endcase
         send_pixel(r, g, b);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // edge pixels: black, white, grays, primaries, ties, near-extremes
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd127, 8'd127, 8'd127);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd200, 8'd10, 8'd60);
      send_pixel(8'd254, 8'd1, 8'd0);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd127, 8'd128, 8'd0);
      send_pixel(8'd170, 8'd85, 8'd85);
      drain_pipeline();

      for (int phase = 0; phase < 6; phase++) begin
         write_reg(hsl_pkg::REG_SAT, sat_values[phase]);
         write_reg(hsl_pkg::REG_HUE, hue_values[phase]);
         case (phase % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 55; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 55; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase
         send_random_pixels(80);
         // hold off the result side with the pipeline full, keep offering
         if (phase == 2) hold_off_count = hold_off_count + 1;
         if (phase == 4) begin
            // pause until all results are back, then resume
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         send_random_pixels(75);
         drain_pipeline();
      end

      $display("covered %0d pixels over 6 offset settings incl. extremes and out-of-range codes",
               pixel_count);
      $display("with idle/stall phases, a long output hold-off and a full drain pause");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

>>> sim.f
design/hsl_pkg.sv
design/hsl_hue_saturation_adjust.sv
sim/hsl_adjust_checker.sv
sim/hsl_hue_saturation_adjust_tb.sv
